[rtl/core/csc_pkg.sv]
// Shared types, constants and elaboration-time table functions for the coordinate converter.
package csc_pkg;

    localparam int GUARD    = 16;
    localparam int ANG_FRAC = 32;
    localparam int XW       = 52;
    localparam int AW       = 42;
    localparam int IGW      = 30;

    localparam logic [63:0] PI_E8  = 64'd314159265;
    localparam logic [63:0] DEG_E8 = 64'd18000000000;

    typedef enum logic [1:0] {
        MODE_CART_SPH = 2'd0,
        MODE_CART_CYL = 2'd1,
        MODE_SPH_CART = 2'd2,
        MODE_CYL_CART = 2'd3
    } t_mode;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] coord_a;
        logic signed [31:0] coord_b;
        logic signed [31:0] coord_c;
    } t_in;

    typedef struct packed {
        logic signed [31:0] out_a;
        logic signed [31:0] out_b;
        logic signed [31:0] out_c;
        logic               saturated;
    } t_out;

    typedef struct packed {
        logic vec;
        logic neg;
        logic zero;
    } t_ctl;

    typedef struct packed {
        t_mode              mode;
        logic signed [31:0] c_raw;
        logic signed [AW-1:0] ang_c;
        logic signed [XW-1:0] p1a;
        logic signed [XW-1:0] p1b;
        logic signed [AW-1:0] p1ang;
    } t_side;

    // shift-subtract division, elaboration only
    function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] q;
        int i;
        rem = '0;
        q   = '0;
        for (i = 63; i >= 0; i--) begin
            rem = {rem[63:0], n[i]};
            if (rem >= {1'b0, d}) begin
                rem  = rem - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] isqrt(input logic [63:0] val);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b_;
        int i;
        v   = val;
        res = '0;
        b_  = 64'd1 << 62;
        for (i = 0; i < 32; i++) begin
            if (v >= res + b_) begin
                v   = v - (res + b_);
                res = (res >> 1) + b_;
            end else begin
                res = res >> 1;
            end
            b_ = b_ >> 2;
        end
        return res;
    endfunction

    // atan(2^-i) in degrees, 32 fraction bits
    function automatic logic [63:0] atan_deg(input int i);
        logic signed [63:0] rad;
        logic signed [63:0] t;
        logic [63:0] r;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] deg;
        int k;
        int sh;
        if (i == 0) begin
            return 64'd45 << ANG_FRAC;
        end
        rad = '0;
        for (k = 0; k < 32; k++) begin
            sh = 56 - i * (2 * k + 1);
            if (sh >= 0) begin
                t   = signed'(udiv(64'd1 << sh, 64'(2 * k + 1)));
                rad = k[0] ? rad - t : rad + t;
            end
        end
        r   = unsigned'(rad);
        q   = udiv(r, PI_E8);
        rem = r - q * PI_E8;
        deg = q * DEG_E8 + udiv(rem * DEG_E8, PI_E8);
        return (deg + (64'd1 << 23)) >> 24;
    endfunction

    // 1/K for n stages, 30 fraction bits
    function automatic logic [63:0] inv_gain(input int n);
        logic [63:0] k2;
        logic [63:0] s;
        int i;
        k2 = 64'd1 << 60;
        for (i = 0; i < n; i++) begin
            k2 = k2 + (k2 >> (2 * i));
        end
        s = isqrt(k2);
        return udiv((64'd1 << 60) + (s >> 1), s);
    endfunction

    // {clipped, value}
    function automatic logic [32:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return {1'b1, 32'h7FFF_FFFF};
        end else if (v < -64'sd2147483648) begin
            return {1'b1, 32'h8000_0000};
        end
        return {1'b0, v[31:0]};
    endfunction

endpackage

[rtl/core/coordinate_system_converter.sv]
// Top level: Cartesian / spherical / cylindrical point converter, two chained CORDIC passes.
// The angle reduction uses N_RED = 33 - clog2(360 << FRAC_BITS) restoring cells ahead of the two
//   CORDIC cell chains and their gain correction.
// Throughput: one beat per cycle; the whole pipeline advances unless the output is stalled.
// Reset: synchronous, active low; clears all valid flags, payload registers are not reset.
module coordinate_system_converter #(
    parameter int FRAC_BITS     = 16,
    parameter int CORDIC_STAGES = 20
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  csc_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output csc_pkg::t_out o_data
);

    localparam int XW  = csc_pkg::XW;
    localparam int AW  = csc_pkg::AW;
    localparam int ASH = csc_pkg::ANG_FRAC - FRAC_BITS;
    localparam logic [63:0] FULL = 64'd360 << FRAC_BITS;
    localparam int N_RED = 33 - $clog2(FULL);
    localparam logic [63:0] C0 = 64'h8000_0000 % FULL;
    localparam logic [63:0] HALF_FULL = FULL / 2;
    localparam logic signed [35:0] FULL_S = 36'(FULL);
    localparam logic signed [35:0] HALF_S = 36'(HALF_FULL);
    localparam logic signed [35:0] C0_S   = 36'(C0);
    localparam logic signed [AW-1:0] HALF  = AW'(180) <<< csc_pkg::ANG_FRAC;
    localparam logic signed [AW-1:0] QUART = AW'(90) <<< csc_pkg::ANG_FRAC;
    localparam logic [csc_pkg::IGW-1:0] INV = csc_pkg::IGW'(csc_pkg::inv_gain(CORDIC_STAGES));

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [AW-1:0] z;
        csc_pkg::t_ctl        ctl;
    } t_seed;

    function automatic logic signed [AW-1:0] ang_norm(input logic [31:0] r);
        logic signed [35:0] m;
        m = signed'({4'b0000, r}) - C0_S;
        if (m < 0) begin
            m = m + FULL_S;
        end
        if (m >= HALF_S) begin
            m = m - FULL_S;
        end
        return AW'(m) <<< ASH;
    endfunction

    function automatic t_seed seed_vec(input logic signed [XW-1:0] x,
                                       input logic signed [XW-1:0] y);
        t_seed s;
        s.ctl.vec  = 1'b1;
        s.ctl.neg  = 1'b0;
        s.ctl.zero = (x == '0) && (y == '0);
        s.x = x;
        s.y = y;
        s.z = '0;
        if (x < 0) begin
            s.z = (y >= 0) ? HALF : -HALF;
            s.x = -x;
            s.y = -y;
        end
        return s;
    endfunction

    function automatic t_seed seed_rot(input logic signed [XW-1:0] r,
                                       input logic signed [AW-1:0] a);
        t_seed s;
        s.ctl.vec  = 1'b0;
        s.ctl.neg  = 1'b0;
        s.ctl.zero = 1'b0;
        s.x = r;
        s.y = '0;
        s.z = a;
        if (a > QUART) begin
            s.z       = a - HALF;
            s.ctl.neg = 1'b1;
        end else if (a < -QUART) begin
            s.z       = a + HALF;
            s.ctl.neg = 1'b1;
        end
        return s;
    endfunction

    function automatic logic [32:0] coord_out(input logic signed [XW-1:0] g);
        logic signed [63:0] w;
        w = 64'(g);
        return csc_pkg::sat32((w + (64'sd1 <<< (csc_pkg::GUARD - 1))) >>> csc_pkg::GUARD);
    endfunction

    function automatic logic [32:0] ang_out(input logic signed [AW-1:0] z);
        logic signed [63:0] w;
        w = 64'(z);
        return csc_pkg::sat32((w + (64'sd1 <<< (ASH - 1))) >>> ASH);
    endfunction

    logic en;

    // angle reduction chain
    logic         mv  [0:N_RED];
    logic [31:0]  mub [0:N_RED];
    logic [31:0]  muc [0:N_RED];
    csc_pkg::t_in mit [0:N_RED];

    logic                 r_a_v;
    csc_pkg::t_in         r_a_in;
    logic signed [AW-1:0] r_a_angb;
    logic signed [AW-1:0] r_a_angc;

    logic           r_i1_v;
    t_seed          r_i1_seed;
    csc_pkg::t_side r_i1_side;
    t_seed          n_i1_seed;
    csc_pkg::t_side n_i1_side;

    logic                 p1_v;
    logic signed [XW-1:0] p1_x;
    logic signed [XW-1:0] p1_y;
    logic signed [AW-1:0] p1_z;
    csc_pkg::t_side       p1_side;

    logic           r_i2_v;
    t_seed          r_i2_seed;
    csc_pkg::t_side r_i2_side;
    t_seed          n_i2_seed;
    csc_pkg::t_side n_i2_side;

    logic                 p2_v;
    logic signed [XW-1:0] p2_x;
    logic signed [XW-1:0] p2_y;
    logic signed [AW-1:0] p2_z;
    csc_pkg::t_side       p2_side;

    logic          r_out_v;
    csc_pkg::t_out r_out;
    csc_pkg::t_out n_out;
    logic [32:0]   sa;
    logic [32:0]   sb;
    logic [32:0]   sc;

    assign o_stall = r_out_v && i_stall;
    assign en      = !o_stall;

    assign mv[0]  = i_valid;
    assign mub[0] = {~i_data.coord_b[31], i_data.coord_b[30:0]};
    assign muc[0] = {~i_data.coord_c[31], i_data.coord_c[30:0]};
    assign mit[0] = i_data;

    for (genvar g = 0; g < N_RED; g++) begin : g_mod
        csc_mod_cell #(
            .DIV (34'(FULL << (N_RED - 1 - g)))
        ) u_mod (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (mv[g]),
            .i_ub    (mub[g]),
            .i_uc    (muc[g]),
            .i_item  (mit[g]),
            .o_valid (mv[g+1]),
            .o_ub    (mub[g+1]),
            .o_uc    (muc[g+1]),
            .o_item  (mit[g+1])
        );
    end

    // first pass seed
    always_comb begin
        n_i1_side.mode  = csc_pkg::t_mode'(r_a_in.req_type);
        n_i1_side.c_raw = r_a_in.coord_c;
        n_i1_side.ang_c = r_a_angc;
        n_i1_side.p1a   = '0;
        n_i1_side.p1b   = '0;
        n_i1_side.p1ang = '0;
        if (r_a_in.req_type[1] == 1'b0) begin
            n_i1_seed = seed_vec(XW'(r_a_in.coord_a) <<< csc_pkg::GUARD,
                                 XW'(r_a_in.coord_b) <<< csc_pkg::GUARD);
        end else begin
            n_i1_seed = seed_rot(XW'(r_a_in.coord_a) <<< csc_pkg::GUARD, r_a_angb);
        end
    end

    // second pass seed
    always_comb begin
        n_i2_side       = p1_side;
        n_i2_side.p1a   = p1_x;
        n_i2_side.p1b   = p1_y;
        n_i2_side.p1ang = p1_z;
        if (p1_side.mode == csc_pkg::MODE_CART_SPH || p1_side.mode == csc_pkg::MODE_CART_CYL) begin
            n_i2_seed = seed_vec(XW'(p1_side.c_raw) <<< csc_pkg::GUARD, p1_x);
        end else begin
            n_i2_seed = seed_rot(p1_y, p1_side.ang_c);
        end
    end

    always_comb begin
        sa = '0;
        sb = '0;
        sc = '0;
        case (p2_side.mode)
            csc_pkg::MODE_CART_SPH: begin
                sa = coord_out(p2_x);
                sb = ang_out(p2_z);
                sc = ang_out(p2_side.p1ang);
            end
            csc_pkg::MODE_CART_CYL: begin
                sa = coord_out(p2_side.p1a);
                sb = ang_out(p2_side.p1ang);
                sc = {1'b0, p2_side.c_raw};
            end
            csc_pkg::MODE_SPH_CART: begin
                sa = coord_out(p2_x);
                sb = coord_out(p2_y);
                sc = coord_out(p2_side.p1a);
            end
            csc_pkg::MODE_CYL_CART: begin
                sa = coord_out(p2_side.p1a);
                sb = coord_out(p2_side.p1b);
                sc = {1'b0, p2_side.c_raw};
            end
            default: begin
                sa = '0;
            end
        endcase
        n_out.out_a     = sa[31:0];
        n_out.out_b     = sb[31:0];
        n_out.out_c     = sc[31:0];
        n_out.saturated = sa[32] | sb[32] | sc[32];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v   <= 1'b0;
            r_i1_v  <= 1'b0;
            r_i2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_a_v   <= mv[N_RED];
            r_i1_v  <= r_a_v;
            r_i2_v  <= p1_v;
            r_out_v <= p2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_in    <= mit[N_RED];
            r_a_angb  <= ang_norm(mub[N_RED]);
            r_a_angc  <= ang_norm(muc[N_RED]);
            r_i1_seed <= n_i1_seed;
            r_i1_side <= n_i1_side;
            r_i2_seed <= n_i2_seed;
            r_i2_side <= n_i2_side;
            r_out     <= n_out;
        end
    end

    csc_pass #(
        .STAGES (CORDIC_STAGES),
        .INV    (INV)
    ) u_pass1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_i1_v),
        .i_x     (r_i1_seed.x),
        .i_y     (r_i1_seed.y),
        .i_z     (r_i1_seed.z),
        .i_ctl   (r_i1_seed.ctl),
        .i_side  (r_i1_side),
        .o_valid (p1_v),
        .o_x     (p1_x),
        .o_y     (p1_y),
        .o_z     (p1_z),
        .o_side  (p1_side)
    );

    csc_pass #(
        .STAGES (CORDIC_STAGES),
        .INV    (INV)
    ) u_pass2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_i2_v),
        .i_x     (r_i2_seed.x),
        .i_y     (r_i2_seed.y),
        .i_z     (r_i2_seed.z),
        .i_ctl   (r_i2_seed.ctl),
        .i_side  (r_i2_side),
        .o_valid (p2_v),
        .o_x     (p2_x),
        .o_y     (p2_y),
        .o_z     (p2_z),
        .o_side  (p2_side)
    );

    assign o_valid = r_out_v;
    assign o_data  = r_out;

endmodule

[rtl/core/csc_mod_cell.sv]
// One restoring step of the input angle reduction modulo a full turn.
module csc_mod_cell #(
    parameter logic [33:0] DIV = 34'd1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [31:0]   i_ub,
    input  logic [31:0]   i_uc,
    input  csc_pkg::t_in  i_item,
    output logic          o_valid,
    output logic [31:0]   o_ub,
    output logic [31:0]   o_uc,
    output csc_pkg::t_in  o_item
);

    logic         r_valid;
    logic [31:0]  r_ub;
    logic [31:0]  r_uc;
    csc_pkg::t_in r_item;
    logic [31:0]  n_ub;
    logic [31:0]  n_uc;

    always_comb begin
        n_ub = ({2'b00, i_ub} >= DIV) ? 32'({2'b00, i_ub} - DIV) : i_ub;
        n_uc = ({2'b00, i_uc} >= DIV) ? 32'({2'b00, i_uc} - DIV) : i_uc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ub   <= n_ub;
            r_uc   <= n_uc;
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_ub    = r_ub;
    assign o_uc    = r_uc;
    assign o_item  = r_item;

endmodule

[rtl/core/csc_cordic_cell.sv]
// One CORDIC micro-rotation, vectoring or rotation chosen per beat.
module csc_cordic_cell #(
    parameter int SHIFT = 0,
    parameter logic signed [csc_pkg::AW-1:0] ATAN = '0
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic signed [csc_pkg::XW-1:0] i_x,
    input  logic signed [csc_pkg::XW-1:0] i_y,
    input  logic signed [csc_pkg::AW-1:0] i_z,
    input  csc_pkg::t_ctl                i_ctl,
    input  csc_pkg::t_side               i_side,
    output logic                         o_valid,
    output logic signed [csc_pkg::XW-1:0] o_x,
    output logic signed [csc_pkg::XW-1:0] o_y,
    output logic signed [csc_pkg::AW-1:0] o_z,
    output csc_pkg::t_ctl                o_ctl,
    output csc_pkg::t_side               o_side
);

    logic                          r_valid;
    logic signed [csc_pkg::XW-1:0] r_x;
    logic signed [csc_pkg::XW-1:0] r_y;
    logic signed [csc_pkg::AW-1:0] r_z;
    csc_pkg::t_ctl                 r_ctl;
    csc_pkg::t_side                r_side;
    logic                          dn;
    logic signed [csc_pkg::XW-1:0] xs;
    logic signed [csc_pkg::XW-1:0] ys;
    logic signed [csc_pkg::XW-1:0] n_x;
    logic signed [csc_pkg::XW-1:0] n_y;
    logic signed [csc_pkg::AW-1:0] n_z;

    always_comb begin
        dn = i_ctl.vec ? i_y[csc_pkg::XW-1] : !i_z[csc_pkg::AW-1];
        xs = i_x >>> SHIFT;
        ys = i_y >>> SHIFT;
        if (dn) begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - ATAN;
        end else begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_ctl  <= i_ctl;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_ctl   = r_ctl;
    assign o_side  = r_side;

endmodule

[rtl/core/csc_gain.sv]
// Two-stage CORDIC gain correction with sign restore, rounding half away from zero.
module csc_gain #(
    parameter logic [csc_pkg::IGW-1:0] INV = '0
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [csc_pkg::XW-1:0] i_v,
    input  logic                          i_neg,
    output logic signed [csc_pkg::XW-1:0] o_p
);

    localparam int HW = csc_pkg::XW - 32;

    logic [csc_pkg::XW-1:0]        mag;
    logic                          r_sgn;
    logic [HW+csc_pkg::IGW-1:0]    r_ph;
    logic [32+csc_pkg::IGW-1:0]    r_pl;
    logic [csc_pkg::XW+1:0]        sum;
    logic signed [csc_pkg::XW-1:0] r_p;

    always_comb begin
        mag = i_v[csc_pkg::XW-1] ? unsigned'(-i_v) : unsigned'(i_v);
        sum = (csc_pkg::XW+2)'({r_ph, 2'b00})
            + (csc_pkg::XW+2)'((64'(r_pl) + (64'd1 << 29)) >> 30);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sgn <= i_v[csc_pkg::XW-1] ^ i_neg;
            r_ph  <= mag[csc_pkg::XW-1:32] * INV;
            r_pl  <= mag[31:0] * INV;
            r_p   <= r_sgn ? -signed'(csc_pkg::XW'(sum)) : signed'(csc_pkg::XW'(sum));
        end
    end

    assign o_p = r_p;

endmodule

[rtl/core/csc_pass.sv]
// One CORDIC pass: a chain of micro-rotation cells, angle wrap and gain correction.
module csc_pass #(
    parameter int STAGES = 20,
    parameter logic [csc_pkg::IGW-1:0] INV = '0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic signed [csc_pkg::XW-1:0] i_x,
    input  logic signed [csc_pkg::XW-1:0] i_y,
    input  logic signed [csc_pkg::AW-1:0] i_z,
    input  csc_pkg::t_ctl                 i_ctl,
    input  csc_pkg::t_side                i_side,
    output logic                          o_valid,
    output logic signed [csc_pkg::XW-1:0] o_x,
    output logic signed [csc_pkg::XW-1:0] o_y,
    output logic signed [csc_pkg::AW-1:0] o_z,
    output csc_pkg::t_side                o_side
);

    localparam logic signed [csc_pkg::AW-1:0] HALF =
        csc_pkg::AW'(180) <<< csc_pkg::ANG_FRAC;

    logic                          cv [0:STAGES];
    logic signed [csc_pkg::XW-1:0] cx [0:STAGES];
    logic signed [csc_pkg::XW-1:0] cy [0:STAGES];
    logic signed [csc_pkg::AW-1:0] cz [0:STAGES];
    csc_pkg::t_ctl                 cc [0:STAGES];
    csc_pkg::t_side                cs [0:STAGES];

    logic                          r_g1_v;
    logic signed [csc_pkg::AW-1:0] r_g1_z;
    csc_pkg::t_side                r_g1_side;
    logic                          r_g2_v;
    logic signed [csc_pkg::AW-1:0] r_g2_z;
    csc_pkg::t_side                r_g2_side;
    logic signed [csc_pkg::AW-1:0] n_g1_z;

    assign cv[0] = i_valid;
    assign cx[0] = i_x;
    assign cy[0] = i_y;
    assign cz[0] = i_z;
    assign cc[0] = i_ctl;
    assign cs[0] = i_side;

    for (genvar g = 0; g < STAGES; g++) begin : g_cell
        csc_cordic_cell #(
            .SHIFT (g),
            .ATAN  (csc_pkg::AW'(csc_pkg::atan_deg(g)))
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (cv[g]),
            .i_x     (cx[g]),
            .i_y     (cy[g]),
            .i_z     (cz[g]),
            .i_ctl   (cc[g]),
            .i_side  (cs[g]),
            .o_valid (cv[g+1]),
            .o_x     (cx[g+1]),
            .o_y     (cy[g+1]),
            .o_z     (cz[g+1]),
            .o_ctl   (cc[g+1]),
            .o_side  (cs[g+1])
        );
    end

    // origin gives angle 0; vectoring result wraps into (-180,180]
    always_comb begin
        n_g1_z = cz[STAGES];
        if (cc[STAGES].zero) begin
            n_g1_z = '0;
        end else if (cc[STAGES].vec) begin
            if (cz[STAGES] > HALF) begin
                n_g1_z = cz[STAGES] - (HALF <<< 1);
            end else if (cz[STAGES] <= -HALF) begin
                n_g1_z = cz[STAGES] + (HALF <<< 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g1_v <= 1'b0;
            r_g2_v <= 1'b0;
        end else if (i_en) begin
            r_g1_v <= cv[STAGES];
            r_g2_v <= r_g1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_g1_z    <= n_g1_z;
            r_g1_side <= cs[STAGES];
            r_g2_z    <= r_g1_z;
            r_g2_side <= r_g1_side;
        end
    end

    csc_gain #(.INV(INV)) u_gain_x (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_v   (cx[STAGES]),
        .i_neg (cc[STAGES].neg),
        .o_p   (o_x)
    );

    csc_gain #(.INV(INV)) u_gain_y (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_v   (cy[STAGES]),
        .i_neg (cc[STAGES].neg),
        .o_p   (o_y)
    );

    assign o_valid = r_g2_v;
    assign o_z     = r_g2_z;
    assign o_side  = r_g2_side;

endmodule

[rtl/core/csc_checker.sv]
// Port-level checks for the coordinate converter, bound to the top level.
module csc_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_stall,
    input csc_pkg::t_in  i_data,
    input logic          o_valid,
    input logic          i_stall,
    input csc_pkg::t_out o_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("output beat changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a held output beat");

    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with empty output register");

endmodule

bind coordinate_system_converter csc_checker u_csc_checker (.*);
